>>> sv/ahfe_pkg.sv
// Package for the ASCII hex frame encoder: widths, frame positions, register
// indexes, the configuration struct and the hex and CRC-8 helper functions.
// No dependencies.
`default_nettype none

package ahfe_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 32;
   localparam int PAY_W     = 64;
   localparam int NIB_W     = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int POS_W     = 5;

   localparam logic [POS_W-1:0] POS_START     = 5'd0;
   localparam logic [POS_W-1:0] POS_HEX_FIRST = 5'd1;
   localparam logic [POS_W-1:0] POS_HEX_LAST  = 5'd16;
   localparam logic [POS_W-1:0] POS_CRC_HI    = 5'd17;
   localparam logic [POS_W-1:0] POS_CRC_LO    = 5'd18;
   localparam logic [POS_W-1:0] POS_TAIL      = 5'd19;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
   localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

   localparam logic [BYTE_W-1:0] START_FLAG_RESET = 8'd126;
   localparam logic [BYTE_W-1:0] TAIL_FLAG_RESET  = 8'd13;
   localparam logic              HEX_UPPER_RESET  = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_FLAG = 2'd0,
      CSR_TAIL_FLAG  = 2'd1,
      CSR_HEX_UPPER  = 2'd2
   } csr_addr_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_flag;
      logic [BYTE_W-1:0] tail_flag;
      logic              hex_upper;
   } cfg_type;

   function automatic logic [BYTE_W-1:0] nibble_char(input logic [NIB_W-1:0] nib,
                                                     input logic upper);
      logic [BYTE_W-1:0] letter_base;
      letter_base = upper ? 8'h41 : 8'h61;
      if (nib < 4'd10) begin
         nibble_char = 8'h30 + {4'd0, nib};
      end else begin
         nibble_char = letter_base + {4'd0, nib - 4'd10};
      end
   endfunction

   function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = crc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if ((c & CRC_TOP) != '0) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      crc8_byte = c;
   endfunction

endpackage

`default_nettype wire

>>> sv/ahfe_if.sv
// Channel interfaces of the frame encoder: command input, frame byte output
// and register write. Depends on ahfe_pkg for field widths.
`default_nettype none

interface ahfe_req_if;
   import ahfe_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] device_type;
   logic [BYTE_W-1:0] dev_address;
   logic [BYTE_W-1:0] info_byte;
   logic [BYTE_W-1:0] command_type;
   logic [WORD_W-1:0] data_word;
   modport source (output valid, device_type, dev_address, info_byte, command_type,
                   data_word, input ready);
   modport sink   (input valid, device_type, dev_address, info_byte, command_type,
                   data_word, output ready);
endinterface

interface ahfe_rsp_if;
   import ahfe_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte;
   logic              last_byte;
   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink   (input valid, frame_byte, last_byte, output ready);
endinterface

interface ahfe_csr_if;
   import ahfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [BYTE_W-1:0]     wdata;
   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

>>> sv/ascii_hex_frame_encoder_crc8.sv
// Top level of the ASCII hex frame encoder with CRC-8 (polynomial 0x07).
// Depends on ahfe_pkg, the channel interfaces, ahfe_csr and ahfe_framer.
//
//   channel   direction  beat
//   req_bus   in         one command: four bytes and a 32-bit data word
//   rsp_bus   out        one frame byte, last_byte set on the tail flag
//   csr_bus   in         one register write: addr and wdata
//
// A command yields 20 bytes, one per cycle while the output is not held, so
// frames stream back to back; the byte-wide output register sets that rate.
// One command waits in a buffer while the previous frame streams; a taken
// command passes the buffer and the sequencer before the output register.
// A low rsp_bus.ready holds a waiting output byte and the byte sequencer.
// Reset clears the control state and loads the register defaults.
`default_nettype none

module ascii_hex_frame_encoder_crc8 (
   input  wire        clock,
   input  wire        reset,
   ahfe_req_if.sink   req_bus,
   ahfe_rsp_if.source rsp_bus,
   ahfe_csr_if.sink   csr_bus
);
   import ahfe_pkg::*;

   cfg_type cfg;

   ahfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ahfe_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

>>> sv/ahfe_csr.sv
// Configuration registers of the frame encoder: start flag, tail flag and
// hex letter case. Depends on ahfe_pkg and ahfe_csr_if.
`default_nettype none

module ahfe_csr (
   input  wire              clock,
   input  wire              reset,
   ahfe_csr_if.sink         csr_bus,
   output ahfe_pkg::cfg_type cfg
);
   import ahfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign csr_bus.ready = 1'b1;
   assign wr            = csr_bus.valid;
   assign cfg           = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_addr_type'(csr_bus.addr))
            CSR_START_FLAG: cfg_in.start_flag = csr_bus.wdata;
            CSR_TAIL_FLAG:  cfg_in.tail_flag  = csr_bus.wdata;
            CSR_HEX_UPPER:  cfg_in.hex_upper  = csr_bus.wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_flag <= START_FLAG_RESET;
         cfg_ff.tail_flag  <= TAIL_FLAG_RESET;
         cfg_ff.hex_upper  <= HEX_UPPER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/ahfe_framer.sv
// Command buffer, frame byte sequencer with running CRC-8 and output register.
// Depends on ahfe_pkg, ahfe_req_if and ahfe_rsp_if.
`default_nettype none

module ahfe_framer (
   input  wire               clock,
   input  wire               reset,
   input  ahfe_pkg::cfg_type cfg,
   ahfe_req_if.sink          req_bus,
   ahfe_rsp_if.source        rsp_bus
);
   import ahfe_pkg::*;

   logic              buf_valid_ff, buf_valid_in;
   logic [PAY_W-1:0]  buf_ff, buf_in;
   logic              active_ff, active_in;
   logic [PAY_W-1:0]  pay_ff, pay_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              emit;
   logic              at_tail;
   logic              load;
   logic              req_take;
   logic [NIB_W-1:0]  nib_sel;
   logic [PAY_W-1:0]  pay_shift;
   logic [BYTE_W-1:0] cur_byte;

   assign emit     = active_ff && (!out_valid_ff || rsp_bus.ready);
   assign at_tail  = (idx_ff == POS_TAIL);
   assign load     = buf_valid_ff && (!active_ff || (emit && at_tail));
   assign req_bus.ready = !buf_valid_ff || load;
   assign req_take = req_bus.valid && req_bus.ready;

   assign nib_sel   = NIB_W'(idx_ff - POS_HEX_FIRST);
   assign pay_shift = pay_ff << {nib_sel, 2'b00};

   always_comb begin
      case (idx_ff)
         POS_START:  cur_byte = cfg.start_flag;
         POS_CRC_HI: cur_byte = nibble_char(crc_ff[7:4], cfg.hex_upper);
         POS_CRC_LO: cur_byte = nibble_char(crc_ff[3:0], cfg.hex_upper);
         POS_TAIL:   cur_byte = cfg.tail_flag;
         default:    cur_byte = nibble_char(pay_shift[PAY_W-1 -: NIB_W], cfg.hex_upper);
      endcase
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      buf_in       = buf_ff;
      active_in    = active_ff;
      pay_in       = pay_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;

      if (load) begin
         buf_valid_in = 1'b0;
      end
      if (req_take) begin
         buf_valid_in = 1'b1;
         buf_in = {req_bus.device_type, req_bus.dev_address, req_bus.info_byte,
                   req_bus.command_type, req_bus.data_word};
      end

      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = at_tail;
         idx_in       = idx_ff + 5'd1;
         if (idx_ff inside {[POS_HEX_FIRST:POS_HEX_LAST]}) begin
            crc_in = crc8_byte(crc_ff, cur_byte);
         end
         if (at_tail) begin
            active_in = 1'b0;
         end
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      if (load) begin
         active_in = 1'b1;
         pay_in    = buf_ff;
         idx_in    = POS_START;
         crc_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= POS_START;
         crc_ff       <= '0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
      end
      buf_ff      <= buf_in;
      pay_ff      <= pay_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.frame_byte = out_byte_ff;
   assign rsp_bus.last_byte  = out_last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff <= POS_TAIL)
      else $error("frame position beyond tail");

   a_buf_starts: assert property (@(posedge clock) disable iff (reset)
      buf_valid_ff && !active_ff |=> active_ff && idx_ff == POS_START)
      else $error("buffered command did not start a frame");

   a_crc_clear: assert property (@(posedge clock) disable iff (reset)
      active_ff && idx_ff == POS_START |-> crc_ff == '0)
      else $error("CRC not cleared at frame start");

endmodule

`default_nettype wire
